@@ rtl/core/grr_pkg.sv @@
// Package for the gamepad report remapper: beat layouts, register indexes,
// reset values and button bit positions.
// No dependencies.
`timescale 1ns / 1ps

package grr_pkg;

  // Input beat: tuser = {pad_detached, pad_present}
  localparam int IN_USER_W = 2;
  localparam int IN_PRESENT_BIT = 0;
  localparam int IN_DETACHED_BIT = 1;
  // Input beat: tdata = {right_y, right_x, left_y, left_x, analog_buttons, digital_buttons}
  localparam int IN_DATA_W = 136;

  // Output beat: tdata = {7'b0, reset_request, right_y_byte, right_x_byte, button_word}
  localparam int OUT_DATA_W = 40;
  localparam int OUT_REQ_BIT = 32;

  // Configuration registers
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_QUICK_SAVE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMBO_THRESH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DEADZONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DEADZONE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMBO_POLLS    = 3'd5;

  localparam logic [7:0]  RST_PRESS_THRESH   = 8'h20;
  localparam logic [7:0]  RST_COMBO_THRESH   = 8'h40;
  localparam logic [14:0] RST_LEFT_DEADZONE  = 15'd13000;
  localparam logic [14:0] RST_RIGHT_DEADZONE = 15'd7000;
  localparam logic [4:0]  RST_COMBO_POLLS    = 5'd20;

  localparam logic [15:0] IDLE_WORD   = 16'hFFFF;
  localparam logic [7:0]  CENTER_BYTE = 8'h80;
  localparam logic [4:0]  COUNT_MAX   = 5'd31;

  // Button word bit positions (active low)
  localparam logic [3:0] BTN_START = 4'd3;
  localparam logic [3:0] BTN_UP    = 4'd4;
  localparam logic [3:0] BTN_RIGHT = 4'd5;
  localparam logic [3:0] BTN_DOWN  = 4'd6;
  localparam logic [3:0] BTN_LEFT  = 4'd7;

  // Analog byte indexes
  localparam int ANA_BLACK = 4;
  localparam int ANA_WHITE = 5;
  localparam int ANA_LT    = 6;
  localparam int ANA_RT    = 7;
  localparam int DIG_START = 4;

  typedef logic [3:0] bit_pos_t;
  // digital bit i -> word bit
  localparam bit_pos_t DIG_BIT [8] = '{4'd4, 4'd6, 4'd7, 4'd5, 4'd3, 4'd0, 4'd1, 4'd2};
  // analog byte i -> word bit
  localparam bit_pos_t ANA_BIT [8] = '{4'd14, 4'd13, 4'd15, 4'd12, 4'd11, 4'd10, 4'd8, 4'd9};

  typedef struct packed {
    logic        quick_save;
    logic [7:0]  press_thresh;
    logic [7:0]  combo_thresh;
    logic [14:0] left_dz;
    logic [14:0] right_dz;
    logic [4:0]  combo_polls;
  } cfg_t;

endpackage

@@ rtl/core/gamepad_report_remapper.sv @@
// Gamepad report remapper: an input beat passes the input register, one level of
// compare logic and the result register; throughput one poll per cycle while the
// output is not stalled. Stick arming and combo count update as each beat
// leaves the input register. rst_n (synchronous) clears both channels' valid flags,
// the arming flags and combo count, and loads register reset values.
`timescale 1ns / 1ps

module gamepad_report_remapper
  import grr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // lsb up: digital_buttons[7:0], analog_buttons[71:8], left_x[87:72], left_y[103:88],
  //         right_x[119:104], right_y[135:120]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // lsb up: pad_present, pad_detached
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // lsb up: button_word[15:0], right_x_byte[23:16], right_y_byte[31:24],
  //         reset_request[32], zero pad[39:33]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;

  logic                 s1_valid_r;
  logic [IN_DATA_W-1:0] s1_data_r;
  logic [IN_USER_W-1:0] s1_user_r;
  logic                 s1_adv;

  logic       left_armed_r, left_armed_nxt;
  logic       right_armed_r, right_armed_nxt;
  logic [4:0] count_r, count_nxt;

  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quick_save   <= 1'b0;
      cfg_r.press_thresh <= RST_PRESS_THRESH;
      cfg_r.combo_thresh <= RST_COMBO_THRESH;
      cfg_r.left_dz      <= RST_LEFT_DEADZONE;
      cfg_r.right_dz     <= RST_RIGHT_DEADZONE;
      cfg_r.combo_polls  <= RST_COMBO_POLLS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_QUICK_SAVE:     cfg_r.quick_save   <= cfg_data[0];
        REG_PRESS_THRESH:   cfg_r.press_thresh <= cfg_data[7:0];
        REG_COMBO_THRESH:   cfg_r.combo_thresh <= cfg_data[7:0];
        REG_LEFT_DEADZONE:  cfg_r.left_dz      <= cfg_data[14:0];
        REG_RIGHT_DEADZONE: cfg_r.right_dz     <= cfg_data[14:0];
        REG_COMBO_POLLS:    cfg_r.combo_polls  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // s1 moves on whenever the result register is empty or being drained
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
    end
  end

  // field split
  logic               present, detached;
  logic [7:0]         dig;
  logic [63:0]        ana;
  logic signed [16:0] lx, ly, rx, ry;
  logic signed [16:0] ldz, rdz;

  assign detached = s1_user_r[IN_DETACHED_BIT];
  assign present  = s1_user_r[IN_PRESENT_BIT] && !detached;
  assign dig      = s1_data_r[7:0];
  assign ana      = s1_data_r[71:8];
  assign lx       = {s1_data_r[87], s1_data_r[87:72]};
  assign ly       = {s1_data_r[103], s1_data_r[103:88]};
  assign rx       = {s1_data_r[119], s1_data_r[119:104]};
  assign ry       = {s1_data_r[135], s1_data_r[135:120]};
  assign ldz      = {2'b00, cfg_r.left_dz};
  assign rdz      = {2'b00, cfg_r.right_dz};

  function automatic logic in_zone(input logic signed [16:0] x, input logic signed [16:0] y,
                                   input logic signed [16:0] dz);
    in_zone = (x > -dz) && (x < dz) && (y > -dz) && (y < dz);
  endfunction

  function automatic logic [7:0] clamp_byte(input logic signed [9:0] v);
    if (v < 10'sd0) begin
      clamp_byte = 8'd0;
    end else if (v > 10'sd255) begin
      clamp_byte = 8'hFF;
    end else begin
      clamp_byte = v[7:0];
    end
  endfunction

  logic               combo;
  logic               req;
  logic [15:0]        word;
  logic signed [16:0] rxa, rya, rxp, ryp;
  logic signed [8:0]  rxq, ryq;
  logic [7:0]         rxb, ryb;

  always_comb begin
    combo = (ana[ANA_LT*8 +: 8] > cfg_r.combo_thresh) &&
            (ana[ANA_RT*8 +: 8] > cfg_r.combo_thresh) &&
            dig[DIG_START] &&
            (ana[ANA_WHITE*8 +: 8] > cfg_r.combo_thresh);

    if (!present || !combo) begin
      count_nxt = 5'd0;
    end else if (count_r < COUNT_MAX) begin
      count_nxt = count_r + 5'd1;
    end else begin
      count_nxt = count_r;
    end
    req = present && combo && (count_nxt >= cfg_r.combo_polls);

    if (detached) begin
      left_armed_nxt  = 1'b0;
      right_armed_nxt = 1'b0;
    end else if (present) begin
      left_armed_nxt  = left_armed_r || in_zone(lx, ly, ldz);
      right_armed_nxt = right_armed_r || in_zone(rx, ry, rdz);
    end else begin
      left_armed_nxt  = left_armed_r;
      right_armed_nxt = right_armed_r;
    end

    word = IDLE_WORD;
    for (int i = 0; i < 8; i++) begin
      if (dig[i]) word[DIG_BIT[i]] = 1'b0;
      if (!(cfg_r.quick_save && (i == ANA_BLACK || i == ANA_WHITE)) &&
          (ana[i*8 +: 8] > cfg_r.press_thresh)) begin
        word[ANA_BIT[i]] = 1'b0;
      end
    end
    if (left_armed_nxt) begin
      if (ly > ldz)  word[BTN_UP]    = 1'b0;
      if (ly < -ldz) word[BTN_DOWN]  = 1'b0;
      if (lx < -ldz) word[BTN_LEFT]  = 1'b0;
      if (lx > ldz)  word[BTN_RIGHT] = 1'b0;
    end

    // unarmed right stick reads as centered
    rxa = right_armed_nxt ? rx : 17'sd0;
    rya = right_armed_nxt ? ry : 17'sd0;
    if (rxa > rdz)       rxp = rxa - rdz;
    else if (rxa < -rdz) rxp = rxa + rdz;
    else                 rxp = 17'sd0;
    if (rya > rdz)       ryp = rya - rdz;
    else if (rya < -rdz) ryp = rya + rdz;
    else                 ryp = 17'sd0;
    // floor divide by 256
    rxq = rxp[16:8];
    ryq = ryp[16:8];
    rxb = clamp_byte(10'sd128 + {rxq[8], rxq});
    ryb = clamp_byte(10'sd128 - {ryq[8], ryq});

    if (present) begin
      out_data_nxt = {7'd0, req, ryb, rxb, word};
    end else begin
      out_data_nxt = {7'd0, 1'b0, CENTER_BYTE, CENTER_BYTE, IDLE_WORD};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_armed_r  <= 1'b0;
      right_armed_r <= 1'b0;
      count_r       <= 5'd0;
    end else if (s1_adv) begin
      left_armed_r  <= left_armed_nxt;
      right_armed_r <= right_armed_nxt;
      count_r       <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/core/grr_checker.sv @@
// Port-level checker for the gamepad report remapper, bound to the top level.
// Depends on grr_pkg for beat layout constants.
`timescale 1ns / 1ps

module grr_checker
  import grr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a reset request needs start held, so the start bit is pressed
  a_req_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_REQ_BIT] |-> !out_tdata[BTN_START])
    else $error("reset request without start pressed");

  // pad field is zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:OUT_REQ_BIT+1] == '0)
    else $error("nonzero pad bits in result beat");

  // with both stages full, input opens only when the result drains
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && in_tvalid && in_tready |=> in_tready == out_tready)
    else $error("input accepted past a full pipeline");

endmodule

bind gamepad_report_remapper grr_checker u_grr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
